@@ hw/rtl/nds_pkg.sv @@
// Shared types and constants for the nibble-packed DNA stream decoder.
// No dependencies; imported by nds_decode, nds_rsp_queue and the top level.
package nds_pkg;

   // Parse phase, one-hot
   typedef enum logic [4:0] {
      PH_SIG  = 5'b00001,
      PH_LEN  = 5'b00010,
      PH_SKIP = 5'b00100,
      PH_DATA = 5'b01000,
      PH_DONE = 5'b10000
   } phase_type;

   // Result status codes
   localparam logic [1:0] ST_BASE     = 2'd0;
   localparam logic [1:0] ST_EMPTY    = 2'd1;
   localparam logic [1:0] ST_BAD_HDR  = 2'd2;
   localparam logic [1:0] ST_PAST_END = 2'd3;

   // Register indexes
   localparam logic CSR_START_BASE = 1'b0;
   localparam logic CSR_MAX_LENGTH = 1'b1;

   localparam logic [30:0] MAX_LENGTH_RESET = 31'h7FFF_FFFF;

   // File signatures, assembled low byte first
   localparam logic [31:0] SIG_NORMAL  = 32'h6BE9_3D3A;
   localparam logic [31:0] SIG_SWAPPED = 32'h3A3D_E96B;

   // Result queue sizing
   localparam int RSP_DEPTH      = 8;
   localparam int RSP_PTR_BITS   = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_BITS   = $clog2(RSP_DEPTH + 1);
   localparam int RSP_ACCEPT_LIM = RSP_DEPTH - 2;

   typedef struct packed {
      logic [6:0]  base_char;
      logic [1:0]  status;
      logic        last;
      logic [31:0] seq_length;
   } rsp_item_type;

   typedef struct packed {
      logic         valid;
      rsp_item_type item;
   } rsp_slot_type;

   // Nibble to ASCII: TCAGNXXX, lower case when bit 3 is set
   function automatic logic [6:0] base_lookup(input logic [3:0] nib);
      logic [6:0] upper;
      case (nib[2:0])
         3'd0:    upper = 7'h54;  // T
         3'd1:    upper = 7'h43;  // C
         3'd2:    upper = 7'h41;  // A
         3'd3:    upper = 7'h47;  // G
         3'd4:    upper = 7'h4E;  // N
         default: upper = 7'h58;  // X
      endcase
      return upper | {1'b0, nib[3], 5'b0_0000};
   endfunction

endpackage

@@ hw/rtl/nds_decode.sv @@
// Input register plus header parser and nibble decoder; one item per cycle.
// Depends on nds_pkg. Emits up to two result slots per item.
module nds_decode #(
   parameter int LENGTH_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_vld,
   input  logic [7:0]           in_data,
   input  logic                 in_sof,
   input  logic [30:0]          start_base,
   input  logic [30:0]          max_length,
   output logic                 pipe_vld,
   output nds_pkg::rsp_slot_type res0,
   output nds_pkg::rsp_slot_type res1
);
   import nds_pkg::*;

   // input register
   logic       pipe_vld_ff;
   logic [7:0] data_ff;
   logic       sof_ff;

   // parse state
   phase_type              phase_ff, phase_in;
   logic [1:0]             cnt_ff, cnt_in;
   logic [31:0]            sig_ff, sig_in;
   logic                   swp_ff, swp_in;
   logic [31:0]            len_ff, len_in;
   logic [29:0]            skip_ff, skip_in;
   logic [LENGTH_BITS-1:0] bases_ff, bases_in;
   logic [LENGTH_BITS-1:0] total_ff, total_in;
   logic                   odd_ff, odd_in;

   // state as seen by this item (start of file clears it)
   phase_type              cur_phase;
   logic [1:0]             cur_cnt;
   logic [31:0]            cur_sig;
   logic                   cur_swp;
   logic [31:0]            cur_len;
   logic [29:0]            cur_skip;
   logic [LENGTH_BITS-1:0] cur_bases;
   logic [LENGTH_BITS-1:0] cur_total;
   logic                   cur_odd;

   logic [31:0]            sig_asm;
   logic [31:0]            len_asm;
   logic [LENGTH_BITS-1:0] count_sat;
   logic [32:0]            diff;
   logic [31:0]            rem_min;
   logic [29:0]            skip_dec;
   logic                   fin1;
   logic                   fin2;

   assign cur_phase = sof_ff ? PH_SIG : phase_ff;
   assign cur_cnt   = sof_ff ? 2'd0 : cnt_ff;
   assign cur_sig   = sof_ff ? 32'd0 : sig_ff;
   assign cur_swp   = sof_ff ? 1'b0 : swp_ff;
   assign cur_len   = sof_ff ? 32'd0 : len_ff;
   assign cur_skip  = sof_ff ? 30'd0 : skip_ff;
   assign cur_bases = sof_ff ? '0 : bases_ff;
   assign cur_total = sof_ff ? '0 : total_ff;
   assign cur_odd   = sof_ff ? 1'b0 : odd_ff;

   assign sig_asm = cur_sig | (32'(data_ff) << {cur_cnt, 3'b000});
   assign len_asm = cur_swp ? {cur_len[23:0], data_ff}
                            : (cur_len | (32'(data_ff) << {cur_cnt, 3'b000}));

   // counts above the length cap saturate
   assign count_sat = ((len_asm >> LENGTH_BITS) != 32'd0) ? '1 : len_asm[LENGTH_BITS-1:0];
   assign diff      = {1'b0, 32'(count_sat)} - {2'b00, start_base};
   assign rem_min   = ({1'b0, max_length} < diff[31:0]) ? {1'b0, max_length} : diff[31:0];
   assign skip_dec  = (cur_skip != 30'd0) ? cur_skip - 30'd1 : 30'd0;
   assign fin1      = (cur_bases == LENGTH_BITS'(1));
   assign fin2      = (cur_bases == LENGTH_BITS'(2));

   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      sig_in   = sig_ff;
      swp_in   = swp_ff;
      len_in   = len_ff;
      skip_in  = skip_ff;
      bases_in = bases_ff;
      total_in = total_ff;
      odd_in   = odd_ff;
      res0     = '0;
      res1     = '0;
      if (pipe_vld_ff) begin
         phase_in = cur_phase;
         cnt_in   = cur_cnt;
         sig_in   = cur_sig;
         swp_in   = cur_swp;
         len_in   = cur_len;
         skip_in  = cur_skip;
         bases_in = cur_bases;
         total_in = cur_total;
         odd_in   = cur_odd;
         case (cur_phase)
            PH_SIG: begin
               sig_in = sig_asm;
               cnt_in = cur_cnt + 2'd1;
               if (cur_cnt == 2'd3) begin
                  if (sig_asm == SIG_NORMAL) begin
                     swp_in   = 1'b0;
                     phase_in = PH_LEN;
                  end else if (sig_asm == SIG_SWAPPED) begin
                     swp_in   = 1'b1;
                     phase_in = PH_LEN;
                  end else begin
                     res0.valid       = 1'b1;
                     res0.item.status = ST_BAD_HDR;
                     res0.item.last   = 1'b1;
                     phase_in         = PH_DONE;
                  end
               end
            end
            PH_LEN: begin
               len_in = len_asm;
               cnt_in = cur_cnt + 2'd1;
               if (cur_cnt == 2'd3) begin
                  if (len_asm == 32'hFFFF_FFFF) begin
                     res0.valid       = 1'b1;
                     res0.item.status = ST_BAD_HDR;
                     res0.item.last   = 1'b1;
                     phase_in         = PH_DONE;
                  end else if (diff[32]) begin
                     res0.valid       = 1'b1;
                     res0.item.status = ST_PAST_END;
                     res0.item.last   = 1'b1;
                     phase_in         = PH_DONE;
                  end else if (rem_min == 32'd0) begin
                     res0.valid       = 1'b1;
                     res0.item.status = ST_EMPTY;
                     res0.item.last   = 1'b1;
                     phase_in         = PH_DONE;
                  end else begin
                     // rem_min never exceeds count_sat, so it fits
                     total_in = rem_min[LENGTH_BITS-1:0];
                     bases_in = rem_min[LENGTH_BITS-1:0];
                     skip_in  = start_base[30:1];
                     odd_in   = start_base[0];
                     phase_in = (start_base[30:1] != 30'd0) ? PH_SKIP : PH_DATA;
                  end
               end
            end
            PH_SKIP: begin
               skip_in = skip_dec;
               if (skip_dec == 30'd0) begin
                  phase_in = PH_DATA;
               end
            end
            PH_DATA: begin
               if (cur_bases != '0) begin
                  res0.valid          = 1'b1;
                  res0.item.status    = ST_BASE;
                  res0.item.base_char = base_lookup(cur_odd ? data_ff[3:0] : data_ff[7:4]);
                  res0.item.last      = fin1;
                  res0.item.seq_length = fin1 ? 32'(cur_total) : 32'd0;
                  odd_in   = 1'b0;
                  bases_in = cur_bases - LENGTH_BITS'(1);
                  if (fin1) begin
                     phase_in = PH_DONE;
                  end else if (!cur_odd) begin
                     // second base of the byte: low nibble
                     res1.valid           = 1'b1;
                     res1.item.status     = ST_BASE;
                     res1.item.base_char  = base_lookup(data_ff[3:0]);
                     res1.item.last       = fin2;
                     res1.item.seq_length = fin2 ? 32'(cur_total) : 32'd0;
                     bases_in = cur_bases - LENGTH_BITS'(2);
                     if (fin2) begin
                        phase_in = PH_DONE;
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_vld_ff <= 1'b0;
         phase_ff    <= PH_SIG;
         cnt_ff      <= 2'd0;
         sig_ff      <= 32'd0;
         swp_ff      <= 1'b0;
         len_ff      <= 32'd0;
         skip_ff     <= 30'd0;
         bases_ff    <= '0;
         total_ff    <= '0;
         odd_ff      <= 1'b0;
      end else begin
         pipe_vld_ff <= in_vld;
         phase_ff    <= phase_in;
         cnt_ff      <= cnt_in;
         sig_ff      <= sig_in;
         swp_ff      <= swp_in;
         len_ff      <= len_in;
         skip_ff     <= skip_in;
         bases_ff    <= bases_in;
         total_ff    <= total_in;
         odd_ff      <= odd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_vld) begin
         data_ff <= in_data;
         sof_ff  <= in_sof;
      end
   end

   assign pipe_vld = pipe_vld_ff;

   // second slot only follows a plain, non-final base in the first
   a_res1_follows: assert property (@(posedge clock) disable iff (reset)
      res1.valid |-> (res0.valid && res0.item.status == ST_BASE && !res0.item.last))
      else $error("second result without a plain first base");

   // any final result ends the file
   a_last_done: assert property (@(posedge clock) disable iff (reset)
      ((res0.valid && res0.item.last) || (res1.valid && res1.item.last))
      |=> (phase_ff == PH_DONE))
      else $error("final result did not close the file");

   // a status result carries no character
   a_status_blank: assert property (@(posedge clock) disable iff (reset)
      (res0.valid && res0.item.status != ST_BASE)
      |-> (res0.item.base_char == 7'd0 && res0.item.last))
      else $error("status result with a character or without last");

endmodule

@@ hw/rtl/nds_rsp_queue.sv @@
// Result queue: takes up to two items per cycle, hands out one per cycle while out_rdy is high.
// Depends on nds_pkg for the slot type and depth.
module nds_rsp_queue (
   input  logic                                  clock,
   input  logic                                  reset,
   input  nds_pkg::rsp_slot_type                 wr0,
   input  nds_pkg::rsp_slot_type                 wr1,
   output logic [nds_pkg::RSP_CNT_BITS-1:0]      count,
   output logic                                  out_vld,
   input  logic                                  out_rdy,
   output nds_pkg::rsp_item_type                 out_item
);
   import nds_pkg::*;

   rsp_item_type             slot_ff [RSP_DEPTH];
   rsp_item_type             slot_in [RSP_DEPTH];
   logic [RSP_CNT_BITS-1:0]  count_ff, count_in;
   logic [RSP_CNT_BITS-1:0]  fill;
   logic [1:0]               nwr;
   logic                     pop;

   assign nwr      = {1'b0, wr0.valid} + {1'b0, wr1.valid};
   assign pop      = out_vld && out_rdy;
   assign fill     = count_ff - RSP_CNT_BITS'(pop);
   assign count_in = fill + RSP_CNT_BITS'(nwr);

   // slot 0 is the head; a pop moves every entry down one place,
   // new items land right behind the last kept entry
   always_comb begin
      for (int i = 0; i < RSP_DEPTH - 1; i++) begin
         slot_in[i] = pop ? slot_ff[i + 1] : slot_ff[i];
      end
      slot_in[RSP_DEPTH-1] = slot_ff[RSP_DEPTH-1];
      if (wr0.valid) begin
         slot_in[fill[RSP_PTR_BITS-1:0]] = wr0.item;
      end
      if (wr1.valid) begin
         slot_in[fill[RSP_PTR_BITS-1:0] + RSP_PTR_BITS'(1)] = wr1.item;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < RSP_DEPTH; i++) begin
         slot_ff[i] <= slot_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign out_vld  = (count_ff != '0);
   assign out_item = slot_ff[0];
   assign count    = count_ff;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= RSP_CNT_BITS'(RSP_DEPTH))
      else $error("result queue overflow");

   a_wr_room: assert property (@(posedge clock) disable iff (reset)
      (wr0.valid || wr1.valid) |-> (count_in <= RSP_CNT_BITS'(RSP_DEPTH)))
      else $error("result queue written while full");

   a_wr_pair: assert property (@(posedge clock) disable iff (reset)
      wr1.valid |-> wr0.valid)
      else $error("second write without a first");

   a_head_hold: assert property (@(posedge clock) disable iff (reset)
      (out_vld && !out_rdy) |=> (out_vld && $stable(out_item)))
      else $error("head item changed while waiting");

endmodule

@@ hw/rtl/nibble_dna_stream_decoder.sv @@
// Nibble-packed DNA stream decoder, top level.
// Depends on nds_pkg, nds_decode and nds_rsp_queue.
//
// Takes a packed DNA file one byte per item on req_ (tuser marks the first byte
// of a file). A 4-byte signature is checked in either byte order, then a 4-byte
// base count is read in that order; start_base/2 bytes are skipped and each
// following byte yields up to two ASCII bases (high nibble first, only the low
// nibble of the first byte when start_base is odd). Exactly
// min(max_length, count - start_base) bases come out on rsp_, the final one with
// tlast set and seq_length filled in. A bad signature, an all-ones count, a
// start past the end or an empty range give a single status item with tlast.
// Bytes after the final item are dropped until the next start of file.
// Flow: a byte is held in the input register, is decoded in one pass
// and its results land in an 8-entry queue; the next byte is taken while the
// queue has room for two results beyond the two that the byte in the input
// register may still add. With rsp_tready held high, data bytes are limited
// by the queue room (two bases per byte on a one-item-per-cycle output);
// header and skip bytes go at one per cycle once the queue holds four results
// or fewer. A byte's results pass the input register and then the queue
// before they are offered on rsp_.
// start_base and max_length are sampled on the last count byte; write them
// between files only.
module nibble_dna_stream_decoder #(
   parameter int LENGTH_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   // input bytes
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] start_of_file
   // results
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [6:0] base_char, [38:7] seq_length, [39] zero
   output logic [1:0]  rsp_tuser,   // [1:0] status
   output logic        rsp_tlast,
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [30:0] csr_data
);
   import nds_pkg::*;

   logic [30:0]             start_base_ff;
   logic [30:0]             max_length_ff;
   logic                    req_acc;
   logic                    pipe_vld;
   rsp_slot_type            res0;
   rsp_slot_type            res1;
   logic [RSP_CNT_BITS-1:0] q_count;
   rsp_item_type            q_item;

   // registers take a write every cycle
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_base_ff <= 31'd0;
         max_length_ff <= MAX_LENGTH_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_START_BASE: start_base_ff <= csr_data;
            CSR_MAX_LENGTH: max_length_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // room for two results per byte, counting the byte in the input register
   assign req_tready = ((RSP_CNT_BITS + 1)'(q_count) + (pipe_vld ? (RSP_CNT_BITS + 1)'(2)
                                                                 : (RSP_CNT_BITS + 1)'(0)))
                       <= (RSP_CNT_BITS + 1)'(RSP_ACCEPT_LIM);
   assign req_acc    = req_tvalid && req_tready;

   nds_decode #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_decode (
      .clock      (clock),
      .reset      (reset),
      .in_vld     (req_acc),
      .in_data    (req_tdata),
      .in_sof     (req_tuser),
      .start_base (start_base_ff),
      .max_length (max_length_ff),
      .pipe_vld   (pipe_vld),
      .res0       (res0),
      .res1       (res1)
   );

   nds_rsp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr0      (res0),
      .wr1      (res1),
      .count    (q_count),
      .out_vld  (rsp_tvalid),
      .out_rdy  (rsp_tready),
      .out_item (q_item)
   );

   assign rsp_tdata = {1'b0, q_item.seq_length, q_item.base_char};
   assign rsp_tuser = q_item.status;
   assign rsp_tlast = q_item.last;

endmodule

@@ dv/nds_checker.sv @@
`timescale 1ns / 1ps
// Result checker for nibble_dna_stream_decoder: follows the byte, result and register
// channels, predicts each result and compares it field by field. Depends on nds_pkg.
module nds_checker #(
   parameter int LENGTH_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,
   input  logic [1:0]  rsp_tuser,
   input  logic        rsp_tlast,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic        csr_index,
   input  logic [30:0] csr_data,
   output int          mismatches,
   output int          results_owed
);
   import nds_pkg::*;

   string        nuc_chars = "TCAGNXXXtcagnxxx";
   rsp_item_type results_due[$];
   int           fail_cnt = 0;

   // decoder state as predicted
   phase_type    ph;
   logic [2:0]   hdr_cnt;
   logic [31:0]  sig_acc;
   logic         swapped;
   logic [31:0]  len_acc;
   logic [30:0]  skip_left;
   logic [31:0]  bases_left;
   logic         odd_pending;
   logic [30:0]  cfg_start;
   logic [30:0]  cfg_max;

   task automatic clear_file();
      ph = PH_SIG;
      hdr_cnt = '0;
      sig_acc = '0;
      swapped = 1'b0;
      len_acc = '0;
      skip_left = '0;
      bases_left = '0;
      odd_pending = 1'b0;
   endtask

   task automatic push_status(input logic [1:0] st);
      rsp_item_type it;
      it.base_char = '0;
      it.status = st;
      it.last = 1'b1;
      it.seq_length = '0;
      results_due.push_back(it);
      ph = PH_DONE;
   endtask

   task automatic push_base(input logic [3:0] nib);
      rsp_item_type it;
      logic [7:0] ch;
      if (bases_left != 0) begin
         bases_left = bases_left - 32'd1;
         ch = nuc_chars[nib];
         it.base_char = ch[6:0];
         it.status = ST_BASE;
         it.last = (bases_left == 0);
         it.seq_length = it.last ? len_acc : 32'd0;
         results_due.push_back(it);
         if (bases_left == 0) ph = PH_DONE;
      end
   endtask

   // count is complete: settle the range against start_base and max_length
   task automatic close_header();
      logic [31:0] count;
      logic [31:0] rem;
      logic [63:0] cap;
      count = len_acc;
      cap = (64'd1 << LENGTH_BITS) - 64'd1;
      if (count == 32'hFFFF_FFFF) begin
         push_status(ST_BAD_HDR);
      end else begin
         if (64'(count) > cap) count = cap[31:0];
         if (32'(cfg_start) > count) begin
            push_status(ST_PAST_END);
         end else begin
            rem = count - 32'(cfg_start);
            if (32'(cfg_max) < rem) rem = 32'(cfg_max);
            if (rem == 0) begin
               push_status(ST_EMPTY);
            end else begin
               len_acc = rem;
               bases_left = rem;
               skip_left = cfg_start >> 1;
               odd_pending = cfg_start[0];
               ph = (skip_left != 0) ? PH_SKIP : PH_DATA;
            end
         end
      end
   endtask

   task automatic decode_byte(input logic [7:0] b, input logic sof);
      if (sof) clear_file();
      case (ph)
         PH_SIG: begin
            sig_acc = sig_acc | (32'(b) << (8 * hdr_cnt[1:0]));
            hdr_cnt = hdr_cnt + 3'd1;
            if (hdr_cnt == 3'd4) begin
               hdr_cnt = '0;
               if (sig_acc == SIG_NORMAL) begin
                  swapped = 1'b0;
                  ph = PH_LEN;
               end else if (sig_acc == SIG_SWAPPED) begin
                  swapped = 1'b1;
                  ph = PH_LEN;
               end else begin
                  push_status(ST_BAD_HDR);
               end
            end
         end
         PH_LEN: begin
            if (swapped) len_acc = {len_acc[23:0], b};
            else len_acc = len_acc | (32'(b) << (8 * hdr_cnt[1:0]));
            hdr_cnt = hdr_cnt + 3'd1;
            if (hdr_cnt == 3'd4) begin
               hdr_cnt = '0;
               close_header();
            end
         end
         PH_SKIP: begin
            if (skip_left != 0) skip_left = skip_left - 31'd1;
            if (skip_left == 0) ph = PH_DATA;
         end
         PH_DATA: begin
            if (odd_pending) begin
               odd_pending = 1'b0;
               push_base(b[3:0]);
            end else begin
               push_base(b[7:4]);
               push_base(b[3:0]);
            end
         end
         default: ;
      endcase
   endtask

   task automatic flag(input string what);
      fail_cnt++;
      if (fail_cnt <= 10) $display("%0t: %s", $time, what);
   endtask

   always @(posedge clock) begin : watch
      rsp_item_type got;
      rsp_item_type want;
      if (reset) begin
         clear_file();
         cfg_start = '0;
         cfg_max = MAX_LENGTH_RESET;
         results_due.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_START_BASE) cfg_start = csr_data;
            else cfg_max = csr_data;
         end
         if (req_tvalid && req_tready) decode_byte(req_tdata, req_tuser);
         if (rsp_tvalid && rsp_tready) begin
            got.base_char = rsp_tdata[6:0];
            got.seq_length = rsp_tdata[38:7];
            got.status = rsp_tuser;
            got.last = rsp_tlast;
            if (results_due.size() == 0) begin
               flag($sformatf("unexpected item: char %h status %0d last %b len %0d",
                              got.base_char, got.status, got.last, got.seq_length));
            end else begin
               want = results_due.pop_front();
               if (got !== want || rsp_tdata[39] !== 1'b0) begin
                  flag($sformatf({"item mismatch: expected char %h status %0d last %b len %0d,",
                                  " got char %h status %0d last %b len %0d pad %b"},
                                 want.base_char, want.status, want.last, want.seq_length,
                                 got.base_char, got.status, got.last, got.seq_length,
                                 rsp_tdata[39]));
               end
            end
         end
      end
      mismatches <= fail_cnt;
      results_owed <= results_due.size();
   end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// Testbench top for nibble_dna_stream_decoder: clock, reset, byte and register
// stimulus, output back-pressure, watchdog and verdict. Depends on nds_pkg, the
// decoder RTL and nds_checker.
module tb;
   import nds_pkg::*;

   localparam int ITEM_TARGET     = 1850;
   localparam int WATCHDOG_LIMIT  = 2000;  // cycles with no item moving on any channel
   localparam int DRAIN_CYCLES    = 12;    // decode pipe plus queue, after last result
   localparam int RSP_HOLD_CYCLES = 80;    // long enough to fill the 8-entry result queue
   localparam int BODY_LIMIT      = 40;    // cap on skip and data bytes per file

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = 1'b0;
   logic [30:0] csr_data = '0;

   int          mismatches;
   int          results_owed;
   int          items_sent = 0;
   int          quiet = 0;
   logic        req_calm = 1'b0;   // sender runs back to back
   logic        rsp_calm = 1'b0;   // receiver never stalls
   logic        hold_rsp = 1'b0;   // request one long receiver hold-off
   logic [30:0] cur_start = '0;
   logic [30:0] cur_max = MAX_LENGTH_RESET;

   nibble_dna_stream_decoder uut (.*);
   nds_checker dna_check (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mostly short gaps, now and then a long one
   function automatic int idle_len();
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // offer one byte and hold it until taken; tvalid stays up for a following item
   task automatic send_byte(input logic [7:0] b, input logic sof, input logic counted);
      int gap;
      gap = 0;
      if (!req_calm && $urandom_range(0, 99) < 35) gap = idle_len();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tuser <= sof;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (counted) items_sent++;
   endtask

   // sender pauses until every predicted result is out and the pipe has drained
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_config(input logic [30:0] start_val, input logic [30:0] max_val);
      csr_valid <= 1'b1;
      csr_index <= CSR_START_BASE;
      csr_data <= start_val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_index <= CSR_MAX_LENGTH;
      csr_data <= max_val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      cur_start = start_val;
      cur_max = max_val;
   endtask

   // One file: signature, count, skip bytes, data bytes. Mostly well formed;
   // some carry a bad signature, an odd count or get cut short by the next file.
   task automatic send_file(input logic long_run);
      logic [31:0] sig;
      logic [31:0] count;
      logic [63:0] rem;
      logic [7:0]  hdr [8];
      logic        swap;
      logic        sig_ok;
      logic        sof_first;
      int          r;
      int          cut;
      int          sent;
      int          n_skip;
      int          n_data;
      swap = 1'($urandom_range(0, 1));
      sig = swap ? SIG_SWAPPED : SIG_NORMAL;
      r = $urandom_range(0, 99);
      if (!long_run && r < 5) sig = $urandom();
      else if (!long_run && r < 9) sig = sig ^ (32'd1 << $urandom_range(0, 31));
      sig_ok = (sig == SIG_NORMAL) || (sig == SIG_SWAPPED);

      r = $urandom_range(0, 99);
      if (long_run) count = 32'(cur_start) + 32'd40;
      else if (r < 5) count = 32'hFFFF_FFFF;                          // all-ones count
      else if (r < 9) count = 32'hFFFF_FFFE - $urandom_range(0, 3);
      else if (r < 15) count = 32'(cur_start);                        // empty range
      else if (r < 22) count = (cur_start == 0) ? 32'd0 : $urandom_range(0, cur_start - 1);
      else if (r < 26) count = $urandom();
      else count = 32'(cur_start) + $urandom_range(1, 40);

      for (int i = 0; i < 4; i++) begin
         hdr[i] = sig[8 * i +: 8];
         hdr[4 + i] = swap ? count[8 * (3 - i) +: 8] : count[8 * i +: 8];
      end

      // expected body size, capped so that huge ranges end by truncation
      n_skip = 0;
      n_data = 0;
      if (sig_ok && count != 32'hFFFF_FFFF && 32'(cur_start) <= count) begin
         rem = 64'(count) - 64'(cur_start);
         if (64'(cur_max) < rem) rem = 64'(cur_max);
         if (rem != 0) begin
            if ((cur_start >> 1) > 31'(BODY_LIMIT)) begin
               n_skip = BODY_LIMIT;
            end else begin
               n_skip = int'(cur_start >> 1);
               rem = cur_start[0] ? rem / 2 + 1 : (rem + 1) / 2;
               n_data = (rem > 64'(BODY_LIMIT)) ? BODY_LIMIT : int'(rem);
            end
         end
      end

      sof_first = long_run || ($urandom_range(0, 19) != 0);
      cut = (!long_run && $urandom_range(0, 9) == 0) ? $urandom_range(1, 12) : 1000;
      sent = 0;
      for (int i = 0; i < 8; i++) begin
         if (sent < cut) begin
            send_byte(hdr[i], (i == 0) && sof_first, sig_ok || i < 4);
            sent++;
         end
      end
      for (int i = 0; i < n_skip + n_data; i++) begin
         if (sent < cut) begin
            send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            sent++;
         end
      end
      // trailing bytes after the body; the block drops them once the file has ended
      if (!long_run && sent < cut && $urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      end
   endtask

   // receiver: random stalls, calm stretches, and one long hold-off on request
   initial begin
      @(posedge clock);
      forever begin
         if ($urandom_range(0, 199) == 0) rsp_calm = !rsp_calm;
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_tready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
         end else if (!rsp_calm && $urandom_range(0, 99) < 25) begin
            rsp_tready <= 1'b0;
            repeat (idle_len()) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
      end
   end

   // watchdog: too long with nothing moving ends the run
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet <= 0;
      end else begin
         quiet <= quiet + 1;
      end
      if (quiet >= WATCHDOG_LIMIT) begin
         $display("tb failed");
         $finish;
      end
   end

   initial begin
      int phase_no;
      logic [30:0] s;
      logic [30:0] m;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      write_config(31'd0, MAX_LENGTH_RESET);

      // Normal order file without a start-of-file flag: the parser sits in the
      // signature phase after reset. Count 16, data walks all 16 nibble codes.
      send_byte(8'h3A, 1'b0, 1'b1);
      send_byte(8'h3D, 1'b0, 1'b1);
      send_byte(8'hE9, 1'b0, 1'b1);
      send_byte(8'h6B, 1'b0, 1'b1);
      send_byte(8'h10, 1'b0, 1'b1);
      send_byte(8'h00, 1'b0, 1'b1);
      send_byte(8'h00, 1'b0, 1'b1);
      send_byte(8'h00, 1'b0, 1'b1);
      for (int i = 0; i < 8; i++) send_byte(8'(i * 8'h22 + 8'h01), 1'b0, 1'b1);
      // bad signature, then a stray byte that must be dropped
      send_byte(8'h00, 1'b1, 1'b1);
      send_byte(8'hFF, 1'b0, 1'b1);
      send_byte(8'h00, 1'b0, 1'b1);
      send_byte(8'hFF, 1'b0, 1'b1);
      send_byte(8'hA5, 1'b0, 1'b0);
      wait_idle();

      phase_no = 0;
      while (items_sent < ITEM_TARGET) begin
         case (phase_no % 8)
            0: begin s = 31'd0;                      m = MAX_LENGTH_RESET; end
            1: begin s = 31'd1;                      m = MAX_LENGTH_RESET; end
            2: begin s = 31'($urandom_range(0, 12)); m = 31'($urandom_range(1, 20)); end
            3: begin s = 31'd0;                      m = 31'd0; end
            4: begin s = 31'h7FFF_FFFF;              m = 31'h7FFF_FFFF; end
            5: begin s = 31'($urandom_range(0, 20)); m = MAX_LENGTH_RESET; end
            6: begin s = 31'($urandom());            m = 31'($urandom()); end
            default: begin s = 31'd3;                m = 31'd1; end
         endcase
         write_config(s, m);
         req_calm = ($urandom_range(0, 3) == 0);
         if (phase_no == 0) begin
            // receiver holds off while a long file streams in, so the block backs up
            hold_rsp = 1'b1;
            req_calm = 1'b1;
            send_file(1'b1);
            req_calm = 1'b0;
         end
         repeat ($urandom_range(6, 12)) send_file(1'b0);
         wait_idle();
         phase_no++;
      end

      if (mismatches == 0 && results_owed == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule
